/* src/dbsg_pkg.sv */
// Package for the de Bruijn sequence generator: widths, status codes,
// command/status structs shared by controller and datapath. No dependencies.
package dbsg_pkg;

  localparam int unsigned MaxEdgesDef    = 4096;
  localparam int unsigned MaxAlphabetDef = 10;
  localparam int unsigned MaxDigitsDef   = 12;

  localparam int unsigned CfgW    = 4;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned StatusW = 2;
  localparam int unsigned IdxW    = 1;

  localparam logic [IdxW-1:0] RegDigitsN   = 1'b0;
  localparam logic [IdxW-1:0] RegAlphabetK = 1'b1;

  localparam logic [StatusW-1:0] StDigit = 2'd0;
  localparam logic [StatusW-1:0] StDone  = 2'd1;
  localparam logic [StatusW-1:0] StError = 2'd2;

  typedef struct packed {
    logic start;      // clear edges and begin a new walk
    logic walk_step;  // advance one walk step
  } dbsg_cmd_t;

  typedef struct packed {
    logic busy;       // a multi-cycle operation is in progress
    logic emit;       // a walk digit was produced this cycle
    logic dry;        // stack emptied without a digit
    logic bad;        // size check failed
    logic [DigitW-1:0] digit;
    logic walk_full;  // node_count reached k^n on this emit
  } dbsg_sts_t;

endpackage

/* src/dbsg_if.sv */
// Valid/ready channel interfaces for the generator.
// No dependencies; field widths are written out.
interface dbsg_req_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface dbsg_rsp_if;
  logic valid;
  logic ready;
  logic [3:0] digit;
  logic       last_digit;
  logic [1:0] status;
  modport source (output valid, output digit, output last_digit, output status, input ready);
  modport sink (input valid, input digit, input last_digit, input status, output ready);
endinterface

interface dbsg_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [3:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/de_bruijn_sequence_generator.sv */
// Top level of the de Bruijn sequence generator (Hierholzer walk).
// Depends on dbsg_pkg, dbsg_if, dbsg_ctrl and dbsg_datapath.
//
//  channel  | dir | payload
//  req      | in  | restart
//  rsp      | out | digit, last_digit, status
//  cfg      | in  | index (0 digits_n, 1 alphabet_k), data
//
// A walk digit takes a read, evaluate and mark step per edge tried and a read
// and evaluate step per frame popped; the answer is valid the cycle after the pop.
// Padding and status answers are valid the cycle after the request.
// A new sequence first sizes k^n, then clears the edge bitmap, one entry per cycle.
// Reset is asynchronous, active low.
// Requests stall while an answer waits or a sizing, clearing or walk step runs.
module de_bruijn_sequence_generator #(
  parameter int unsigned MaxEdges    = dbsg_pkg::MaxEdgesDef,
  parameter int unsigned MaxAlphabet = dbsg_pkg::MaxAlphabetDef,
  parameter int unsigned MaxDigits   = dbsg_pkg::MaxDigitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  dbsg_req_if.sink   req,
  dbsg_rsp_if.source rsp,
  dbsg_cfg_if.sink   cfg
);
  import dbsg_pkg::*;

  logic [3:0] digits_n_q, alphabet_k_q;
  logic       cfg_wr;
  dbsg_cmd_t  cmd;
  dbsg_sts_t  sts;

  assign cfg.ready = 1'b1;
  assign cfg_wr = cfg.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_n_q   <= 4'd2;
      alphabet_k_q <= 4'd2;
    end else if (cfg_wr) begin
      unique case (cfg.index)
        RegDigitsN:   digits_n_q   <= cfg.data;
        RegAlphabetK: alphabet_k_q <= cfg.data;
        default: ;
      endcase
    end
  end

  dbsg_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .cfg_wr_i(cfg_wr), .digits_n_i(digits_n_q),
    .req_valid_i(req.valid), .req_ready_o(req.ready), .req_restart_i(req.restart),
    .rsp_valid_o(rsp.valid), .rsp_ready_i(rsp.ready), .rsp_digit_o(rsp.digit),
    .rsp_last_o(rsp.last_digit), .rsp_status_o(rsp.status),
    .cmd_o(cmd), .sts_i(sts)
  );

  dbsg_datapath #(.MaxEdges(MaxEdges), .MaxAlphabet(MaxAlphabet), .MaxDigits(MaxDigits))
    u_dp (
    .clk_i, .rst_ni,
    .digits_n_i(digits_n_q), .alphabet_k_i(alphabet_k_q),
    .cmd_i(cmd), .sts_o(sts)
  );

endmodule

/* src/dbsg_datapath.sv */
// Datapath: edge bitmap memory, frame stack memory, size check and walk.
// Depends on dbsg_pkg.
module dbsg_datapath #(
  parameter int unsigned MaxEdges    = dbsg_pkg::MaxEdgesDef,
  parameter int unsigned MaxAlphabet = dbsg_pkg::MaxAlphabetDef,
  parameter int unsigned MaxDigits   = dbsg_pkg::MaxDigitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [3:0]             digits_n_i,
  input  logic [3:0]             alphabet_k_i,
  input  dbsg_pkg::dbsg_cmd_t    cmd_i,
  output dbsg_pkg::dbsg_sts_t    sts_o
);
  import dbsg_pkg::*;

  localparam int unsigned EW = $clog2(MaxEdges);
  localparam int unsigned LW = $clog2(MaxEdges + 2);
  localparam int unsigned SD = MaxEdges + 1;
  localparam int unsigned SW = $clog2(SD);
  localparam int unsigned TW = EW + 1;

  // walk micro-states
  localparam logic [2:0] WSize  = 3'd0;
  localparam logic [2:0] WClear = 3'd1;
  localparam logic [2:0] WRead  = 3'd2;
  localparam logic [2:0] WEval  = 3'd3;
  localparam logic [2:0] WMark  = 3'd4;
  localparam logic [2:0] WIdle  = 3'd5;

  logic [2:0] ws_q, ws_d;

  // size check: multiply k in n times, one factor per cycle
  logic [TW-1:0] tot_q, tot_d;
  logic [3:0]    cnt_q, cnt_d;
  logic          big_q, big_d;
  logic [TW+3:0] prod;

  // frame stack memory, payload {node, next, entry}
  logic [EW+DigitW+DigitW-1:0] stk_mem [SD];
  logic [EW-1:0]     f_node_q;
  logic [DigitW-1:0] f_next_q, f_entry_q;
  logic [LW-1:0]     lvl_q, lvl_d;
  logic [TW-1:0]     ncnt_q, ncnt_d;
  logic              used_mem [MaxEdges];
  logic              used_rd_q;
  logic [EW-1:0]     clr_q, clr_d;
  logic [TW-1:0]     nodes_q;   // k^(n-1)

  logic              stk_we;
  logic [SW-1:0]     stk_wa;
  logic [EW+DigitW+DigitW-1:0] stk_wd;
  logic              use_we;
  logic [EW-1:0]     use_wa;
  logic              use_wd;
  logic [SW-1:0]     stk_ra;
  logic [EW+DigitW+2:0] e_wide;
  logic [EW+DigitW+2:0] e_q;

  assign prod = tot_q * alphabet_k_i;
  // edge number node*k + next; child = (node mod k^(n-2))*k + next equals e mod nodes
  assign e_wide = (EW+DigitW+3)'(f_node_q) * (EW+DigitW+3)'(alphabet_k_i)
                  + (EW+DigitW+3)'(f_next_q);

  // e < k*nodes, so e mod nodes = e - q*nodes for the largest q < k that fits
  logic [EW-1:0] child_r;
  logic          found;
  always_comb begin
    child_r = '0;
    found   = 1'b0;
    for (int q = MaxAlphabet - 1; q >= 0; q--) begin
      if (!found && e_q >= (EW+DigitW+3)'(q) * (EW+DigitW+3)'(nodes_q)) begin
        child_r = EW'(e_q - (EW+DigitW+3)'(q) * (EW+DigitW+3)'(nodes_q));
        found   = 1'b1;
      end
    end
  end

  always_comb begin
    ws_d   = ws_q;
    tot_d  = tot_q;
    cnt_d  = cnt_q;
    big_d  = big_q;
    lvl_d  = lvl_q;
    ncnt_d = ncnt_q;
    clr_d  = clr_q;
    stk_we = 1'b0;
    stk_wa = '0;
    stk_wd = '0;
    use_we = 1'b0;
    use_wa = '0;
    use_wd = 1'b0;
    stk_ra = SW'(lvl_q - LW'(1));
    sts_o  = '0;
    sts_o.busy = 1'b1;
    unique case (ws_q)
      WSize: begin
        if (cnt_q == '0) begin
          sts_o.bad = big_q;
          ws_d = big_q ? WIdle : WClear;
          clr_d = '0;
        end else begin
          if (prod > (TW+4)'(MaxEdges)) big_d = 1'b1;
          else tot_d = TW'(prod);
          cnt_d = cnt_q - 4'd1;
        end
      end
      WClear: begin
        use_we = 1'b1;
        use_wa = clr_q;
        clr_d  = clr_q + EW'(1);
        if (clr_q == EW'(MaxEdges - 1)) begin
          stk_we = 1'b1;
          stk_wa = '0;
          stk_wd = '0;
          lvl_d  = LW'(1);
          ncnt_d = '0;
          ws_d   = WIdle;
        end
      end
      WRead: ws_d = WEval;  // stack read data lands
      WEval: begin
        if (lvl_q == '0) begin
          sts_o.dry = 1'b1;
          ws_d = WIdle;
        end else if ({1'b0, f_next_q} < {1'b0, alphabet_k_i}) begin
          stk_we = 1'b1;
          stk_wa = SW'(lvl_q - LW'(1));
          stk_wd = {f_node_q, f_next_q + DigitW'(1), f_entry_q};
          ws_d   = WMark;
        end else begin
          lvl_d = lvl_q - LW'(1);
          if (lvl_q == LW'(1)) begin
            sts_o.dry = 1'b1;
            ws_d = WIdle;
          end else begin
            sts_o.emit  = 1'b1;
            sts_o.digit = f_entry_q;
            ncnt_d = ncnt_q + TW'(1);
            sts_o.walk_full = (ncnt_q + TW'(1)) >= tot_q;
            ws_d = WIdle;
          end
        end
      end
      WMark: begin
        if (e_q < (EW+DigitW+3)'(MaxEdges) && !used_rd_q) begin
          use_we = 1'b1;
          use_wa = EW'(e_q);
          use_wd = 1'b1;
          stk_we = 1'b1;
          stk_wa = SW'(lvl_q);
          stk_wd = {child_r, DigitW'(0), DigitW'(f_next_q - DigitW'(1))};
          lvl_d  = lvl_q + LW'(1);
        end
        ws_d = WRead;
        stk_ra = SW'(used_rd_q || e_q >= (EW+DigitW+3)'(MaxEdges) ? lvl_q - LW'(1) : lvl_q);
      end
      default: sts_o.busy = 1'b0;
    endcase
    if (cmd_i.start) begin
      ws_d  = WSize;
      tot_d = TW'(1);
      cnt_d = digits_n_i;
      big_d = (digits_n_i == '0) || (alphabet_k_i == '0) ||
              ({1'b0, digits_n_i} > 5'(MaxDigits)) ||
              ({1'b0, alphabet_k_i} > 5'(MaxAlphabet));
    end else if (cmd_i.walk_step) begin
      ws_d = WRead;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q   <= WIdle;
      tot_q  <= '0;
      cnt_q  <= '0;
      big_q  <= 1'b0;
      lvl_q  <= '0;
      ncnt_q <= '0;
      clr_q  <= '0;
    end else begin
      ws_q   <= ws_d;
      tot_q  <= tot_d;
      cnt_q  <= cnt_d;
      big_q  <= big_d;
      lvl_q  <= lvl_d;
      ncnt_q <= ncnt_d;
      clr_q  <= clr_d;
    end
  end

  // k^(n-1): tot/k, tracked as the total before the last factor
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) nodes_q <= TW'(1);
    else if (ws_q == WSize && cnt_q == 4'd1) nodes_q <= tot_q;
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_we && stk_wa == stk_ra) {f_node_q, f_next_q, f_entry_q} <= stk_wd;
    else {f_node_q, f_next_q, f_entry_q} <= stk_mem[stk_ra];
    if (use_we) used_mem[use_wa] <= use_wd;
    used_rd_q <= used_mem[EW'(e_wide)];
    e_q <= e_wide;
  end

endmodule

/* src/dbsg_ctrl.sv */
// Controller: request/response handshake, phase tracking and padding.
// Depends on dbsg_pkg.
module dbsg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_i,
  input  logic [3:0]          digits_n_i,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  logic                req_restart_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output logic [3:0]          rsp_digit_o,
  output logic                rsp_last_o,
  output logic [1:0]          rsp_status_o,
  output dbsg_pkg::dbsg_cmd_t cmd_o,
  input  dbsg_pkg::dbsg_sts_t sts_i
);
  import dbsg_pkg::*;

  localparam logic [2:0] PIdle  = 3'd0;
  localparam logic [2:0] PWalk  = 3'd1;
  localparam logic [2:0] PPad   = 3'd2;
  localparam logic [2:0] PDone  = 3'd3;
  localparam logic [2:0] PStart = 3'd4;  // sizing/clearing
  localparam logic [2:0] PStep  = 3'd5;  // walking for a digit
  localparam logic [2:0] PErr   = 3'd6;

  logic [2:0] ph_q, ph_d;
  logic [3:0] pad_q, pad_d;
  logic       ov_q, ov_d;
  logic [3:0] od_q, od_d;
  logic       ol_q, ol_d;
  logic [1:0] os_q, os_d;
  logic       take;
  logic       fresh;

  assign req_ready_o = !ov_q && (ph_q == PIdle || ph_q == PWalk || ph_q == PPad ||
                                 ph_q == PDone || ph_q == PErr);
  assign take = req_valid_i && req_ready_o;
  assign rsp_valid_o  = ov_q;
  assign rsp_digit_o  = od_q;
  assign rsp_last_o   = ol_q;
  assign rsp_status_o = os_q;
  assign fresh = req_restart_i || ph_q == PIdle || ph_q == PErr;

  always_comb begin
    ph_d = ph_q; pad_d = pad_q; ov_d = ov_q; od_d = od_q; ol_d = ol_q; os_d = os_q;
    cmd_o = '0;
    if (ov_q && rsp_ready_i) ov_d = 1'b0;
    unique case (ph_q)
      PStart: begin
        if (sts_i.bad) begin
          ph_d = PErr; ov_d = 1'b1; od_d = '0; ol_d = 1'b0; os_d = StError;
        end else if (!sts_i.busy) begin
          cmd_o.walk_step = 1'b1; ph_d = PStep;
        end
      end
      PStep: begin
        if (sts_i.emit) begin
          ov_d = 1'b1; od_d = sts_i.digit; os_d = StDigit; ol_d = 1'b0;
          ph_d = PWalk;
          if (sts_i.walk_full) begin
            if (digits_n_i > 4'd1) begin ph_d = PPad; pad_d = digits_n_i - 4'd1; end
            else begin ph_d = PDone; ol_d = 1'b1; end
          end
        end else if (sts_i.dry) begin
          ov_d = 1'b1; od_d = '0; os_d = StDigit;
          if (digits_n_i > 4'd1) begin
            pad_d = digits_n_i - 4'd2; ol_d = (digits_n_i == 4'd2);
            ph_d = (digits_n_i == 4'd2) ? PDone : PPad;
          end else begin
            ph_d = PDone; ol_d = 1'b0; os_d = StDone;
          end
        end
      end
      default: begin
        if (take) begin
          if (fresh) begin
            cmd_o.start = 1'b1; ph_d = PStart;
          end else if (ph_q == PWalk) begin
            cmd_o.walk_step = 1'b1; ph_d = PStep;
          end else if (ph_q == PPad) begin
            pad_d = (pad_q != '0) ? pad_q - 4'd1 : pad_q;
            ov_d = 1'b1; od_d = '0; os_d = StDigit;
            ol_d = (pad_d == '0);
            if (pad_d == '0) ph_d = PDone;
          end else begin
            ov_d = 1'b1; od_d = '0; ol_d = 1'b0; os_d = StDone;
          end
        end
      end
    endcase
    if (cfg_wr_i) ph_d = PIdle;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PIdle; pad_q <= '0; ov_q <= 1'b0;
    end else begin
      ph_q <= ph_d; pad_q <= pad_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d; ol_q <= ol_d; os_q <= os_d;
  end

`ifndef SYNTHESIS
  a_err_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PErr && ov_q) |-> os_q == StError) else $error("error phase bad status");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PStep || ph_q == PStart) |-> !req_ready_o) else $error("request taken while busy");
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ol_q) |-> (ph_q == PDone || ph_q == PIdle)) else $error("last digit not final");
`endif

endmodule
